>>> sv/dcfb_pkg.sv
// ----------------------------------------------------------------------------
// dcfb_pkg
// Shared types and constants for the LED matrix chain frame builder.
// ----------------------------------------------------------------------------
package dcfb_pkg;

	// chain and shadow geometry
	localparam int MAX_DEVICES   = 8;
	localparam int ROWS          = 8;
	localparam int SHADOW_DEPTH  = MAX_DEVICES * ROWS;
	localparam int SHADOW_AW     = $clog2(SHADOW_DEPTH);
	localparam int DEV_W         = 3;
	localparam int ROW_W         = 3;
	localparam int CNT_W         = 4;

	// driver register addresses
	localparam logic [3:0] OPC_NOP       = 4'd0;
	localparam logic [3:0] OPC_INTENSITY = 4'd10;
	localparam logic [3:0] OPC_SCANLIMIT = 4'd11;
	localparam logic [3:0] OPC_SHUTDOWN  = 4'd12;

	// value limits
	localparam logic [7:0] INTENSITY_MAX = 8'd15;
	localparam logic [7:0] SCANLIMIT_MAX = 8'd7;
	localparam logic [ROW_W-1:0] ROW_LAST = 3'd7;

	// command codes
	typedef enum logic [2:0] {
		FN_SET_LED   = 3'd0,
		FN_SET_ROW   = 3'd1,
		FN_SET_COL   = 3'd2,
		FN_CLEAR     = 3'd3,
		FN_SHUTDOWN  = 3'd4,
		FN_INTENSITY = 3'd5,
		FN_SCANLIMIT = 3'd6
	} func_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MOD,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture command word
		logic rd;         // read shadow row
		logic modify;     // update shadow, set frame payload
		logic word_load;  // load next frame word into output register
		logic next_row;   // advance to next row of a multi-frame command
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_ok;      // incoming command produces output
		logic out_free;   // output register can take a word
		logic word_last;  // current word is device 0's
		logic row_last;   // current frame is the command's final one
	} dp_sts_t;

endpackage

>>> sv/daisy_chain_led_frame_builder_top.sv
// ----------------------------------------------------------------------------
// daisy_chain_led_frame_builder_top
// Frame builder for a serial chain of up to eight LED matrix driver chips.
// ----------------------------------------------------------------------------
// Each command word (set LED, row or column, clear, shutdown, intensity, scan
// limit) is turned into one or eight frames of 16-bit words, one word per chip
// in the chain, farthest chip first; chips other than the target get no-op
// words. A row shadow of 64 bytes, zero after reset, holds the LED state. Each
// frame is a shadow read, an update, then one word per cycle into the output
// register while the output is not back-pressured. Commands to a chip beyond
// device_count, an unused function code and out-of-range intensity or scan
// limit are dropped. device_count must be written only while no command is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module daisy_chain_led_frame_builder_top
	import dcfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// command words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // device[2:0], row[5:3], column[8:6], value[16:9], bit_on[17]
	input  logic [2:0]  s_tuser,   // func[2:0]
	// chain length
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	// frame words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // opcode[3:0], data[11:4]
	output logic        m_tuser,   // frame_end[0]
	output logic        m_tlast
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	dcfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dcfb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> sv/dcfb_ram.sv
// ----------------------------------------------------------------------------
// dcfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dcfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/dcfb_ctrl.sv
// ----------------------------------------------------------------------------
// dcfb_ctrl
// Command sequencer: read, modify and frame-emit steps for each row frame.
// ----------------------------------------------------------------------------
module dcfb_ctrl
	import dcfb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (sts.in_ok) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_MOD;
			end
			ST_MOD: begin
				cmd.modify = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.word_load = 1'b1;
					if (sts.word_last) begin
						if (sts.row_last) begin
							state_d = ST_IDLE;
						end else begin
							cmd.next_row = 1'b1;
							state_d      = ST_READ;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> sv/dcfb_dp.sv
// ----------------------------------------------------------------------------
// dcfb_dp
// Datapath: command registers, row shadow with valid bits, frame word output.
// ----------------------------------------------------------------------------
module dcfb_dp
	import dcfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// command word
	input  logic [23:0] s_tdata,
	input  logic [2:0]  s_tuser,
	// chain length register
	input  logic        cfg_valid,
	input  logic [3:0]  cfg_data,
	// frame words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast,
	// control
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts
);

	// incoming fields
	logic [DEV_W-1:0] in_dev;
	logic [ROW_W-1:0] in_row;
	logic [2:0]       in_col;
	logic [7:0]       in_val;
	logic             in_bit;
	func_t            in_func;
	logic             in_ok;

	assign in_dev  = s_tdata[2:0];
	assign in_row  = s_tdata[5:3];
	assign in_col  = s_tdata[8:6];
	assign in_val  = s_tdata[16:9];
	assign in_bit  = s_tdata[17];
	assign in_func = func_t'(s_tuser);

	logic [CNT_W-1:0] dev_cnt_q;
	func_t            func_q;
	logic [DEV_W-1:0] dev_q;
	logic [ROW_W-1:0] row_q;
	logic [2:0]       col_q;
	logic [7:0]       val_q;
	logic             bit_q;
	logic [DEV_W-1:0] k_q;
	logic [3:0]       opc_q;
	logic [7:0]       byte_q;
	logic             multi;

	// chain length register; out-of-range values select the full chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_cnt_q <= CNT_W'(MAX_DEVICES);
		end else if (cfg_valid) begin
			if (cfg_data == '0 || cfg_data > CNT_W'(MAX_DEVICES)) begin
				dev_cnt_q <= CNT_W'(MAX_DEVICES);
			end else begin
				dev_cnt_q <= cfg_data;
			end
		end
	end

	// command filter: target in chain, known code, value in range
	always_comb begin
		in_ok = {1'b0, in_dev} < dev_cnt_q;
		case (s_tuser)
			FN_SET_LED, FN_SET_ROW, FN_SET_COL, FN_CLEAR, FN_SHUTDOWN: ;
			FN_INTENSITY: if (in_val > INTENSITY_MAX) in_ok = 1'b0;
			FN_SCANLIMIT: if (in_val > SCANLIMIT_MAX) in_ok = 1'b0;
			default: in_ok = 1'b0;
		endcase
	end

	assign sts.in_ok = in_ok;

	assign multi = (func_q == FN_SET_COL) || (func_q == FN_CLEAR);

	// command capture and row walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			dev_q  <= in_dev;
			col_q  <= in_col;
			val_q  <= in_val;
			bit_q  <= in_bit;
			if (in_func == FN_SET_COL || in_func == FN_CLEAR) begin
				row_q <= '0;
			end else begin
				row_q <= in_row;
			end
		end else if (cmd.next_row) begin
			row_q <= row_q + ROW_W'(1);
		end
	end

	// shadow memory and per-entry valid bits
	logic [SHADOW_AW-1:0]    addr;
	logic [7:0]              rdata;
	logic [SHADOW_DEPTH-1:0] vld_q;
	logic                    rd_vld_q;
	logic                    we;
	logic [7:0]              new_byte;
	logic [7:0]              base;
	logic [7:0]              mask;
	logic                    led_on;

	assign addr = {dev_q, row_q};

	dcfb_ram #(
		.WIDTH(8),
		.DEPTH(SHADOW_DEPTH)
	) u_shadow (
		.clk   (clk),
		.we    (we),
		.waddr (addr),
		.wdata (new_byte),
		.re    (cmd.rd),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				rd_vld_q <= vld_q[addr];
			end
			if (we) begin
				vld_q[addr] <= 1'b1;
			end
		end
	end

	// row update; unwritten entries read as zero
	always_comb begin
		base     = rd_vld_q ? rdata : 8'h00;
		mask     = 8'h80 >> col_q;
		led_on   = bit_q;
		we       = 1'b0;
		new_byte = base;
		case (func_q)
			FN_SET_LED, FN_SET_COL: begin
				if (func_q == FN_SET_COL) begin
					led_on = val_q[ROW_LAST - row_q];
				end
				new_byte = led_on ? (base | mask) : (base & ~mask);
				we       = cmd.modify;
			end
			FN_SET_ROW: begin
				new_byte = val_q;
				we       = cmd.modify;
			end
			FN_CLEAR: begin
				new_byte = 8'h00;
				we       = cmd.modify;
			end
			default: ;
		endcase
	end

	// frame payload for the target device
	always_ff @(posedge clk) begin
		if (cmd.modify) begin
			k_q <= DEV_W'(dev_cnt_q - CNT_W'(1));
			case (func_q)
				FN_SHUTDOWN: begin
					opc_q  <= OPC_SHUTDOWN;
					byte_q <= bit_q ? 8'h00 : 8'h01;
				end
				FN_INTENSITY: begin
					opc_q  <= OPC_INTENSITY;
					byte_q <= val_q;
				end
				FN_SCANLIMIT: begin
					opc_q  <= OPC_SCANLIMIT;
					byte_q <= val_q;
				end
				default: begin
					opc_q  <= {1'b0, row_q} + 4'd1;
					byte_q <= new_byte;
				end
			endcase
		end else if (cmd.word_load) begin
			k_q <= k_q - DEV_W'(1);
		end
	end

	assign sts.word_last = (k_q == '0);
	assign sts.row_last  = !multi || (row_q == ROW_LAST);
	assign sts.out_free  = !m_tvalid || m_tready;

	// output word register: farthest device first, no-op for others
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.word_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.word_load) begin
			if (k_q == dev_q) begin
				m_tdata <= {4'd0, byte_q, opc_q};
			end else begin
				m_tdata <= {4'd0, 8'h00, OPC_NOP};
			end
			m_tuser <= sts.word_last;
			m_tlast <= sts.word_last && sts.row_last;
		end
	end

endmodule
